FILE: rtl/rotary_position_mode_controller_defines.svh
// Assertion macros shared by the checker of the rotary position mode controller.
// Depends on nothing; each macro expects signals named clock and reset in scope.
`ifndef ROTARY_POSITION_MODE_CONTROLLER_DEFINES_SVH
`define ROTARY_POSITION_MODE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define RPMC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define RPMC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/rpmc_pkg.sv
// Shared types, codes and helper functions of the rotary position mode controller.
// Depends on nothing; every RTL module imports it.
package rpmc_pkg;

   // Angles in 1/16 degree, one full turn is 360 degrees.
   typedef logic [12:0] angle_type;
   typedef logic [11:0] tol_type;
   typedef logic [14:0] speed_type;
   typedef logic [14:0] mag_type;
   typedef logic [2:0]  cmd_type;
   typedef logic [1:0]  mode_type;
   typedef logic [1:0]  phase_type;
   typedef logic [1:0]  dir_type;
   typedef logic [2:0]  csr_index_type;
   typedef logic [14:0] csr_data_type;

   localparam angle_type FULL_TURN = 13'd5760;
   localparam angle_type HALF_TURN = FULL_TURN / 2;
   localparam mag_type   ANG_HIGH  = 15'(FULL_TURN / 12);
   localparam mag_type   ANG_MED   = 15'(FULL_TURN / 36);
   localparam mag_type   SPD_HIGH  = 15'd480;
   localparam mag_type   SPD_MED   = 15'd160;
   localparam tol_type   TOL_RESET = 12'd16;

   // Motor command codes.
   localparam cmd_type CMD_STOP    = 3'd0;
   localparam cmd_type LVL_LOW     = 3'd1;
   localparam cmd_type LVL_MED     = 3'd2;
   localparam cmd_type LVL_HIGH    = 3'd3;
   localparam cmd_type CCW_OFFSET  = 3'd3;

   // Mode codes.
   localparam mode_type MODE_STOPPED = 2'd0;
   localparam mode_type MODE_MANUAL  = 2'd1;
   localparam mode_type MODE_SCAN    = 2'd2;
   localparam mode_type MODE_ROTATE  = 2'd3;

   // Scan phase codes.
   localparam phase_type PHASE_TO_START = 2'd0;
   localparam phase_type PHASE_TO_END   = 2'd1;
   localparam phase_type PHASE_BACK     = 2'd2;

   // Approach direction codes.
   localparam dir_type DIR_SHORTEST = 2'd0;
   localparam dir_type DIR_CW       = 2'd1;
   localparam dir_type DIR_CCW      = 2'd2;

   // Configuration register indexes.
   localparam csr_index_type CSR_MODE_SELECT      = 3'd0;
   localparam csr_index_type CSR_MANUAL_TARGET    = 3'd1;
   localparam csr_index_type CSR_SCAN_START       = 3'd2;
   localparam csr_index_type CSR_SCAN_END         = 3'd3;
   localparam csr_index_type CSR_FIXED_SPEED      = 3'd4;
   localparam csr_index_type CSR_ANGLE_TOLERANCE  = 3'd5;
   localparam csr_index_type CSR_ROTATE_DIRECTION = 3'd6;

   // Result of the drive-toward-target logic.
   typedef struct packed {
      logic    arrived;
      cmd_type command;
   } drive_result_type;

   // Reduce a 13-bit angle into one turn; a single subtract covers every 13-bit code.
   function automatic angle_type wrap_angle(input angle_type a);
      return (a >= FULL_TURN) ? angle_type'(a - FULL_TURN) : a;
   endfunction

   // Map a direction and a magnitude onto one of the six moving commands.
   function automatic cmd_type pick_level(input logic cw, input mag_type mag,
                                          input mag_type hi, input mag_type med);
      cmd_type lvl;
      lvl = (mag > hi) ? LVL_HIGH : ((mag > med) ? LVL_MED : LVL_LOW);
      return cw ? lvl : cmd_type'(lvl + CCW_OFFSET);
   endfunction

endpackage

FILE: rtl/rpmc_drive.sv
// Drive-toward-target logic: modular distance, arrival test and command level.
// Depends on rpmc_pkg.
module rpmc_drive
   import rpmc_pkg::*;
(
   input  angle_type        cur_angle,
   input  angle_type        tgt_angle,
   input  tol_type          tolerance,
   input  dir_type          direction,
   output drive_result_type result
);

   angle_type cur_w;
   angle_type tgt_w;
   angle_type cw_dist;
   angle_type ccw_dist;
   angle_type short_mag;
   logic      short_pos;
   angle_type mag;
   logic      pos;

   // Clockwise distance from the current angle to the target, within one turn.
   always_comb begin
      cur_w = wrap_angle(cur_angle);
      tgt_w = wrap_angle(tgt_angle);
      if (tgt_w >= cur_w) begin
         cw_dist = angle_type'(tgt_w - cur_w);
      end else begin
         cw_dist = angle_type'(tgt_w + FULL_TURN - cur_w);
      end
      ccw_dist  = (cw_dist == '0) ? '0 : angle_type'(FULL_TURN - cw_dist);
      short_pos = (cw_dist != '0) && (cw_dist < HALF_TURN);
      short_mag = (cw_dist >= HALF_TURN) ? ccw_dist : cw_dist;
   end

   // Pick the error for the approach direction; code 3 behaves as shortest path.
   always_comb begin
      case (direction)
         DIR_CW: begin
            mag = cw_dist;
            pos = (cw_dist != '0);
         end
         DIR_CCW: begin
            mag = ccw_dist;
            pos = 1'b0;
         end
         default: begin
            mag = short_mag;
            pos = short_pos;
         end
      endcase
   end

   // Arrival always uses the shortest distance; inside tolerance the motor stops.
   always_comb begin
      result.arrived = ({3'b0, short_mag} < {4'b0, tolerance} ? 1'b1 : 1'b0) == 1'b1
                       ? 1'b1 : 1'b0;
      if (mag < angle_type'(tolerance)) begin
         result.command = CMD_STOP;
      end else begin
         result.command = pick_level(pos, mag_type'(mag), ANG_HIGH, ANG_MED);
      end
   end

endmodule

FILE: rtl/rotary_position_mode_controller.sv
// Rotary position mode controller: request register, mode logic and result register.
// Depends on rpmc_pkg and rpmc_drive.
//
// Usage: each control tick sends one request carrying the encoder angle on req_*.
// A request is taken at a rising edge with req_valid high and req_stall low. The block
// answers with at most one result on rsp_*: the motor command and the mode in effect
// after the tick. A scanning tick that reaches its phase target advances the phase and
// gives no result.
// A request accepted into the request register is evaluated and its result loaded into
// the result register. Throughput is one request per cycle while rsp_stall is low; the
// figure is set by the single stage of compare logic between the request register and
// the result register.
// When the receiver holds rsp_stall, the result register keeps its contents and the
// request register still takes one more request; req_stall rises only while both
// registers are full and the result is stalled.
// Configuration goes through csr_write_enable, csr_index and csr_write_data, one
// register per cycle, while no request is in flight. Writing the mode reloads the
// active mode; writing scanning also restarts the sweep at the start angle.
// Synchronous reset empties both registers, selects stopped mode, clears the scan
// phase and restores the register defaults (tolerance one degree).
module rotary_position_mode_controller
   import rpmc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  angle_type     req_encoder_angle,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output cmd_type       rsp_motor_command,
   output mode_type      rsp_active_mode_now,
   input  logic          csr_write_enable,
   input  csr_index_type csr_index,
   input  csr_data_type  csr_write_data
);

   logic             req_valid_ff;
   angle_type        req_angle_ff;
   logic             rsp_valid_ff;
   cmd_type          rsp_cmd_ff;
   mode_type         rsp_mode_ff;
   mode_type         active_mode_ff;
   mode_type         active_mode_in;
   phase_type        scan_phase_ff;
   phase_type        scan_phase_in;
   angle_type        manual_target_ff;
   angle_type        scan_start_ff;
   angle_type        scan_end_ff;
   speed_type        fixed_speed_ff;
   tol_type          angle_tolerance_ff;
   dir_type          rotate_direction_ff;
   angle_type        target;
   drive_result_type drive;
   logic             advance;
   logic             emit;
   cmd_type          cmd;
   mode_type         tick_mode;
   phase_type        tick_phase;
   mag_type          speed_mag;

   // Handshake: the request stage moves on unless the result register is full and stalled.
   assign advance   = req_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = req_valid_ff && rsp_valid_ff && rsp_stall;

   // Target angle for the active mode and scan phase.
   assign target = (active_mode_ff == MODE_MANUAL) ? manual_target_ff :
                   ((scan_phase_ff == PHASE_TO_END) ? scan_end_ff : scan_start_ff);

   rpmc_drive u_drive (
      .cur_angle (req_angle_ff),
      .tgt_angle (target),
      .tolerance (angle_tolerance_ff),
      .direction (rotate_direction_ff),
      .result    (drive)
   );

   // Magnitude of the signed rotating speed; the most negative value fits unsigned.
   assign speed_mag = fixed_speed_ff[14] ? speed_type'(-fixed_speed_ff) : fixed_speed_ff;

   // Per-tick mode behavior.
   always_comb begin
      tick_mode  = active_mode_ff;
      tick_phase = scan_phase_ff;
      emit       = 1'b1;
      cmd        = CMD_STOP;
      case (active_mode_ff)
         MODE_MANUAL: begin
            if (drive.arrived) begin
               tick_mode = MODE_STOPPED;
            end else begin
               cmd = drive.command;
            end
         end
         MODE_SCAN: begin
            if (drive.arrived) begin
               emit       = 1'b0;
               tick_phase = (scan_phase_ff == PHASE_TO_END) ? PHASE_BACK : PHASE_TO_END;
            end else begin
               cmd = drive.command;
            end
         end
         MODE_ROTATE: begin
            if (fixed_speed_ff != '0) begin
               cmd = pick_level(!fixed_speed_ff[14], speed_mag, SPD_HIGH, SPD_MED);
            end
         end
         default: begin
            cmd = CMD_STOP;
         end
      endcase
   end

   // Next mode state: a mode write reloads it, otherwise a processed tick updates it.
   always_comb begin
      active_mode_in = active_mode_ff;
      scan_phase_in  = scan_phase_ff;
      if (csr_write_enable && (csr_index == CSR_MODE_SELECT)) begin
         active_mode_in = csr_write_data[1:0];
         if (csr_write_data[1:0] == MODE_SCAN) begin
            scan_phase_in = PHASE_TO_START;
         end
      end else if (advance) begin
         active_mode_in = tick_mode;
         scan_phase_in  = tick_phase;
      end
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff        <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         active_mode_ff      <= MODE_STOPPED;
         scan_phase_ff       <= PHASE_TO_START;
         manual_target_ff    <= '0;
         scan_start_ff       <= '0;
         scan_end_ff         <= '0;
         fixed_speed_ff      <= '0;
         angle_tolerance_ff  <= TOL_RESET;
         rotate_direction_ff <= DIR_SHORTEST;
      end else begin
         active_mode_ff <= active_mode_in;
         scan_phase_ff  <= scan_phase_in;

         if (req_valid && !req_stall) begin
            req_valid_ff <= 1'b1;
         end else if (advance) begin
            req_valid_ff <= 1'b0;
         end

         if (advance && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_write_enable) begin
            case (csr_index)
               CSR_MANUAL_TARGET:    manual_target_ff    <= csr_write_data[12:0];
               CSR_SCAN_START:       scan_start_ff       <= csr_write_data[12:0];
               CSR_SCAN_END:         scan_end_ff         <= csr_write_data[12:0];
               CSR_FIXED_SPEED:      fixed_speed_ff      <= csr_write_data;
               CSR_ANGLE_TOLERANCE:  angle_tolerance_ff  <= csr_write_data[11:0];
               CSR_ROTATE_DIRECTION: rotate_direction_ff <= csr_write_data[1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers; the request angle loads on acceptance, the result on emission.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_angle_ff <= req_encoder_angle;
      end
      if (advance && emit) begin
         rsp_cmd_ff  <= cmd;
         rsp_mode_ff <= tick_mode;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_motor_command   = rsp_cmd_ff;
   assign rsp_active_mode_now = rsp_mode_ff;

endmodule

FILE: rtl/rpmc_checker.sv
// Port-level checker for the rotary position mode controller, bound to the top level.
// Depends on rpmc_pkg and rotary_position_mode_controller_defines.svh.
`include "rotary_position_mode_controller_defines.svh"

module rpmc_checker
   import rpmc_pkg::*;
(
   input logic          clock,
   input logic          reset,
   input logic          req_stall,
   input logic          rsp_valid,
   input logic          rsp_stall,
   input cmd_type       rsp_motor_command,
   input mode_type      rsp_active_mode_now
);

   // Only seven command codes exist.
   `RPMC_ASSERT_NOW(a_cmd_range, rsp_valid,
      rsp_motor_command <= cmd_type'(LVL_HIGH + CCW_OFFSET), "motor command out of range")

   // A result that reports stopped mode must carry the stop command.
   `RPMC_ASSERT_NOW(a_stopped_stops, rsp_valid && (rsp_active_mode_now == MODE_STOPPED),
      rsp_motor_command == CMD_STOP, "stopped mode with a moving command")

   // The request side stalls only while a finished result is itself stalled.
   `RPMC_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid && rsp_stall,
      "request stalled without a stalled result")

   // A stalled result stays put.
   `RPMC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_motor_command) && $stable(rsp_active_mode_now),
      "stalled request result changed")

endmodule

bind rotary_position_mode_controller rpmc_checker u_rpmc_checker (.*);
